// ----- rtl/core/assert_macros.svh -----
// assert_macros.svh: concurrent assertion helpers for the bin grid RTL.
// Expects clk and rst_n in the including scope; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BGC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BGC_ASSERT_SAME(lbl, ante, cons, msg)
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/bgc_pkg.sv -----
// bgc_pkg: types, codes and constants shared by the bin grid controller,
// datapath and top level. No dependencies.
package bgc_pkg;

    localparam int CORDIC_STEPS = 61;
    localparam int MUL_STEPS    = 24;
    localparam int DMUL_STEPS   = 2;
    localparam int DDIV_STEPS   = 25;
    localparam int SQRT_STEPS   = 64;
    localparam int DEG_W        = 25;
    localparam int OUT_W        = 63;

    localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] SPACING_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] CORNER_TRIG = 2'd2;
    localparam logic [1:0] CORNER_SKIP = 2'd3;

    localparam logic CFG_INLINE = 1'b0;
    localparam logic CFG_CROSS  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SMALL   = 2'd1,
        ST_NOCOORD = 2'd2,
        ST_ZERO    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR_SMALL,
        OP_ERR_NOCOORD,
        OP_SC_LOAD,
        OP_SC_DIV,
        OP_SC_SAVE,
        OP_DIFF,
        OP_MUL,
        OP_SQRT,
        OP_ERR_ZERO,
        OP_NORM_LOAD,
        OP_NORM,
        OP_CORDIC,
        OP_DMUL,
        OP_DDIV,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic       store;
        op_t        op;
        logic [5:0] step;
        logic [1:0] corner;
    } cmd_t;

    typedef struct packed {
        logic too_small;
        logic no_coord;
        logic sp_zero;
        logic norm_done;
    } stat_t;

    // atan(2^-i) in Q60 radians by its series, evaluated at elaboration
    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        int          k;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60 >> 2;
        end
        else begin
            for (k = 0; k < 64; k++) begin
                e = 60 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    acc  = k[0] ? acc - term : acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/core/bgc_ctrl.sv -----
// bgc_ctrl: sequencer for the bin grid computation.
// Depends on bgc_pkg; drives bgc_dp through cmd_t and reads stat_t back.
module bgc_ctrl
    import bgc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] corner_index,
    output logic       busy,
    output cmd_t       cmd,
    input  stat_t      stat
);

    localparam logic [5:0] DIV_LAST    = 6'(32 + FRAC_BITS - 1);
    localparam logic [5:0] MUL_LAST    = 6'(MUL_STEPS);
    localparam logic [5:0] SQRT_LAST   = 6'(SQRT_STEPS - 1);
    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);
    localparam logic [5:0] DMUL_LAST   = 6'(DMUL_STEPS);
    localparam logic [5:0] DDIV_LAST   = 6'(DDIV_STEPS - 1);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_CHECK   = 14'b00000000000010,
        S_SC_LOAD = 14'b00000000000100,
        S_SC_DIV  = 14'b00000000001000,
        S_SC_SAVE = 14'b00000000010000,
        S_DIFF    = 14'b00000000100000,
        S_MUL     = 14'b00000001000000,
        S_SQRT    = 14'b00000010000000,
        S_SPCHK   = 14'b00000100000000,
        S_NORM    = 14'b00001000000000,
        S_CORDIC  = 14'b00010000000000,
        S_DMUL    = 14'b00100000000000,
        S_DDIV    = 14'b01000000000000,
        S_FINISH  = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] corner_reg, corner_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        cmd.store   = 1'b0;
        cmd.op      = OP_NONE;
        cmd.step    = step_reg;
        cmd.corner  = corner_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && corner_index != CORNER_SKIP)
                begin
                    cmd.store = 1'b1;
                    if (corner_index == CORNER_TRIG)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.too_small)
                begin
                    cmd.op     = OP_ERR_SMALL;
                    state_next = S_IDLE;
                end
                else if (stat.no_coord)
                begin
                    cmd.op     = OP_ERR_NOCOORD;
                    state_next = S_IDLE;
                end
                else
                begin
                    corner_next = 2'd0;
                    state_next  = S_SC_LOAD;
                end
            end
            S_SC_LOAD:
            begin
                cmd.op     = OP_SC_LOAD;
                step_next  = '0;
                state_next = S_SC_DIV;
            end
            S_SC_DIV:
            begin
                cmd.op    = OP_SC_DIV;
                step_next = step_reg + 6'd1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_SC_SAVE;
                end
            end
            S_SC_SAVE:
            begin
                cmd.op = OP_SC_SAVE;
                if (corner_reg == CORNER_TRIG)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = S_SC_LOAD;
                end
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op    = OP_MUL;
                step_next = step_reg + 6'd1;
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op    = OP_SQRT;
                step_next = step_reg + 6'd1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = S_SPCHK;
                end
            end
            S_SPCHK:
            begin
                if (stat.sp_zero)
                begin
                    cmd.op     = OP_ERR_ZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_NORM_LOAD;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op = OP_NORM;
                if (stat.norm_done)
                begin
                    step_next  = '0;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                cmd.op    = OP_CORDIC;
                step_next = step_reg + 6'd1;
                if (step_reg == CORDIC_LAST)
                begin
                    step_next  = '0;
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                cmd.op    = OP_DMUL;
                step_next = step_reg + 6'd1;
                if (step_reg == DMUL_LAST)
                begin
                    step_next  = '0;
                    state_next = S_DDIV;
                end
            end
            S_DDIV:
            begin
                cmd.op    = OP_DDIV;
                step_next = step_reg + 6'd1;
                if (step_reg == DDIV_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
        end
    end

endmodule

// ----- rtl/core/bgc_dp.sv -----
// bgc_dp: corner stores, grid registers and arithmetic units (scalar divider,
// 32x32 multiplier with accumulators, square roots, CORDIC, degree divider).
// Depends on bgc_pkg; steered by bgc_ctrl through cmd_t.
module bgc_dp
    import bgc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [1:0]         corner_index,
    input  logic signed [31:0] cdp_x,
    input  logic signed [31:0] cdp_y,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    input  logic signed [15:0] coord_scalar,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [62:0] origin_x,
    output logic signed [62:0] origin_y,
    output logic signed [24:0] azimuth,
    output logic signed [62:0] inline_spacing,
    output logic signed [62:0] crossline_spacing
);

    localparam int          QW     = 32 + FRAC_BITS;
    localparam logic [63:0] DEG_K  = 64'(180) << FRAC_BITS;
    localparam logic [63:0] HALF_PI = PI_Q60 >> 1;

    localparam logic [2:0] DST_IXX = 3'd0;
    localparam logic [2:0] DST_IYY = 3'd1;
    localparam logic [2:0] DST_XXX = 3'd2;
    localparam logic [2:0] DST_XYY = 3'd3;
    localparam logic [2:0] DST_M1  = 3'd4;
    localparam logic [2:0] DST_M2  = 3'd5;
    localparam logic [2:0] DST_DEG = 3'd6;

    // corner stores and grid size
    logic signed [31:0] cdpx_reg [3];
    logic signed [31:0] cdpy_reg [3];
    logic signed [31:0] srcx_reg [3];
    logic signed [31:0] srcy_reg [3];
    logic signed [15:0] scal_reg [3];
    logic [15:0]        il_cnt_reg, xl_cnt_reg;

    // scaling
    logic signed [47:0] prodx_reg, prody_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic signed [15:0] s_reg;
    logic [15:0]        dvs_reg;
    logic [QW-1:0]      dnx_reg, dny_reg;
    logic [16:0]        drx_reg, dry_reg;
    logic               negx_reg, negy_reg;
    logic signed [63:0] px_reg [3];
    logic signed [63:0] py_reg [3];

    // differences
    logic signed [63:0] il_dx_reg, il_dy_reg, xl_dx_reg, xl_dy_reg;
    logic [63:0]        uix_reg, uiy_reg, uxx_reg, uxy_reg;

    // multiplier and accumulators
    logic [63:0]  pp_reg;
    logic [2:0]   pp_p_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_v_reg;
    logic [127:0] acc_i_reg, acc_x_reg, acc_m1_reg, acc_m2_reg, deg_acc_reg;

    // square roots
    logic [127:0] rem_i_reg, root_i_reg, rem_x_reg, root_x_reg;

    // CORDIC and degree divider
    logic signed [63:0] cx_reg, cy_reg, cz_reg;
    logic [63:0]        dr_reg;
    logic [DEG_W-1:0]   dq_reg;

    // results
    logic               strobe_reg;
    status_t            status_reg;
    logic signed [62:0] org_x_reg, org_y_reg, il_sp_reg, xl_sp_reg;
    logic signed [24:0] az_reg;

    logic [63:0] atan_tab [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_atan
        localparam logic [63:0] ATAN_G = atan_pow2(g);
        assign atan_tab[g] = ATAN_G;
    end

    function automatic logic [QW+16:0] div_step(input logic [16:0] rem,
                                                input logic [QW-1:0] num,
                                                input logic [15:0] d);
        logic [17:0] t;
        logic        q;
        logic [16:0] r;
        t = {rem, num[QW-1]};
        q = (t >= {2'b00, d});
        r = q ? 17'(t - {2'b00, d}) : t[16:0];
        return {r, num[QW-2:0], q};
    endfunction

    function automatic logic [255:0] sqrt_step(input logic [127:0] rem,
                                               input logic [127:0] root,
                                               input logic [127:0] bitv);
        logic [127:0] trial;
        trial = root + bitv;
        if (rem >= trial)
            return {rem - trial, (root >> 1) + bitv};
        else
            return {rem, root >> 1};
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // status toward the controller
    logic cdp_any, src_any;
    logic [63:0] norm_m;

    always_comb
    begin
        cdp_any = 1'b0;
        src_any = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            cdp_any = cdp_any | (cdpx_reg[c] != '0) | (cdpy_reg[c] != '0);
            src_any = src_any | (srcx_reg[c] != '0) | (srcy_reg[c] != '0);
        end
    end

    assign norm_m         = ($unsigned(cx_reg) > $unsigned(cy_reg)) ? cx_reg : cy_reg;
    assign stat.too_small = (il_cnt_reg < 16'd2) || (xl_cnt_reg < 16'd2);
    assign stat.no_coord  = !cdp_any && !src_any;
    assign stat.sp_zero   = (root_i_reg[63:0] == '0) || (root_x_reg[63:0] == '0);
    assign stat.norm_done = (norm_m[63:41] == '0) && norm_m[40];

    // scaling operands for the selected corner
    logic signed [31:0] vx_sel, vy_sel;
    logic signed [15:0] s_sel;
    logic [31:0]        vx_mag, vy_mag;

    assign vx_sel = cdp_any ? cdpx_reg[cmd.corner] : srcx_reg[cmd.corner];
    assign vy_sel = cdp_any ? cdpy_reg[cmd.corner] : srcy_reg[cmd.corner];
    assign s_sel  = scal_reg[cmd.corner];
    assign vx_mag = vx_sel[31] ? 32'(-vx_sel) : 32'(vx_sel);
    assign vy_mag = vy_sel[31] ? 32'(-vy_sel) : 32'(vy_sel);

    logic [QW+16:0] divx_res, divy_res;

    assign divx_res = div_step(drx_reg, dnx_reg, dvs_reg);
    assign divy_res = div_step(dry_reg, dny_reg, dvs_reg);

    logic signed [63:0] qx_s, qy_s, px_new, py_new;

    always_comb
    begin
        qx_s = signed'(64'(dnx_reg));
        qy_s = signed'(64'(dny_reg));
        if (s_reg > 16'sd0)
        begin
            px_new = 64'(prodx_reg) <<< FRAC_BITS;
            py_new = 64'(prody_reg) <<< FRAC_BITS;
        end
        else if (s_reg == 16'sd0)
        begin
            px_new = 64'(vx_reg) <<< FRAC_BITS;
            py_new = 64'(vy_reg) <<< FRAC_BITS;
        end
        else
        begin
            px_new = negx_reg ? -qx_s : qx_s;
            py_new = negy_reg ? -qy_s : qy_s;
        end
    end

    // angle magnitude for the degree conversion
    logic [63:0] phi, deg_mag;

    always_comb
    begin
        if (cz_reg[63])
            phi = '0;
        else if ($unsigned(cz_reg) > HALF_PI)
            phi = HALF_PI;
        else
            phi = cz_reg;
        deg_mag = il_dy_reg[63] ? PI_Q60 - phi : phi;
    end

    // multiplier operand selection
    logic [63:0] mul_a, mul_b;
    logic [1:0]  mul_k;
    logic [2:0]  mul_p;
    logic        mul_v;
    logic [31:0] half_a, half_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_k = '0;
        mul_p = DST_IXX;
        mul_v = 1'b0;
        if (cmd.op == OP_MUL && cmd.step < 6'(MUL_STEPS))
        begin
            mul_v = 1'b1;
            mul_p = cmd.step[4:2];
            mul_k = cmd.step[1:0];
            case (mul_p)
                DST_IXX: begin mul_a = uix_reg; mul_b = uix_reg; end
                DST_IYY: begin mul_a = uiy_reg; mul_b = uiy_reg; end
                DST_XXX: begin mul_a = uxx_reg; mul_b = uxx_reg; end
                DST_XYY: begin mul_a = uxy_reg; mul_b = uxy_reg; end
                DST_M1:  begin mul_a = uiy_reg; mul_b = uxx_reg; end
                DST_M2:  begin mul_a = uix_reg; mul_b = uxy_reg; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (cmd.op == OP_DMUL && cmd.step < 6'(DMUL_STEPS))
        begin
            mul_v = 1'b1;
            mul_p = DST_DEG;
            mul_k = {cmd.step[0], 1'b0};
            mul_a = deg_mag;
            mul_b = DEG_K;
        end
    end

    assign half_a = mul_k[1] ? mul_a[63:32] : mul_a[31:0];
    assign half_b = mul_k[0] ? mul_b[63:32] : mul_b[31:0];

    logic [127:0] addend;

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    addend = {64'd0, pp_reg};
            2'd1:    addend = {32'd0, pp_reg, 32'd0};
            default: addend = {pp_reg, 64'd0};
        endcase
    end

    // square root step
    logic [127:0] sq_bit, sri_rem, sri_root, srx_rem, srx_root;
    logic [255:0] sqi_res, sqx_res;

    assign sq_bit   = 128'd1 << (7'd126 - {cmd.step, 1'b0});
    assign sri_rem  = (cmd.step == '0) ? acc_i_reg : rem_i_reg;
    assign sri_root = (cmd.step == '0) ? '0 : root_i_reg;
    assign srx_rem  = (cmd.step == '0) ? acc_x_reg : rem_x_reg;
    assign srx_root = (cmd.step == '0) ? '0 : root_x_reg;
    assign sqi_res  = sqrt_step(sri_rem, sri_root, sq_bit);
    assign sqx_res  = sqrt_step(srx_rem, srx_root, sq_bit);

    // degree division step
    logic [63:0] dd_rem, dd_t;
    logic [4:0]  dd_idx;
    logic        dd_q;

    assign dd_idx = 5'(6'd24 - cmd.step);
    assign dd_rem = (cmd.step == '0) ? {1'b0, deg_acc_reg[87:25]} : dr_reg;
    assign dd_t   = {dd_rem[62:0], deg_acc_reg[dd_idx]};
    assign dd_q   = (dd_t >= PI_Q60);

    // final fields
    logic [62:0] isp_sat, xsp_sat;
    logic        s1_neg, s2_neg, xl_neg;

    assign isp_sat = (root_i_reg[63:0] > SPACING_MAX) ? SPACING_MAX[62:0] : root_i_reg[62:0];
    assign xsp_sat = (root_x_reg[63:0] > SPACING_MAX) ? SPACING_MAX[62:0] : root_x_reg[62:0];
    assign s1_neg  = (il_dy_reg != '0) && (xl_dx_reg != '0) && (il_dy_reg[63] != xl_dx_reg[63]);
    assign s2_neg  = (il_dx_reg != '0) && (xl_dy_reg != '0) && (il_dx_reg[63] != xl_dy_reg[63]);
    assign xl_neg  = (s1_neg && s2_neg)
                   || (s1_neg && !s2_neg && (acc_m1_reg > acc_m2_reg))
                   || (s2_neg && !s1_neg && (acc_m2_reg > acc_m1_reg));

    logic cordic_go;
    assign cordic_go = (cmd.op == OP_CORDIC) && (cy_reg != '0);

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cdpx_reg[c] <= '0;
                cdpy_reg[c] <= '0;
                srcx_reg[c] <= '0;
                srcy_reg[c] <= '0;
                scal_reg[c] <= '0;
            end
            il_cnt_reg <= '0;
            xl_cnt_reg <= '0;
            pp_v_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                cdpx_reg[corner_index] <= cdp_x;
                cdpy_reg[corner_index] <= cdp_y;
                srcx_reg[corner_index] <= source_x;
                srcy_reg[corner_index] <= source_y;
                scal_reg[corner_index] <= coord_scalar;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INLINE: il_cnt_reg <= cfg_data;
                    CFG_CROSS:  xl_cnt_reg <= cfg_data;
                    default:    il_cnt_reg <= il_cnt_reg;
                endcase
            end
            pp_v_reg   <= mul_v;
            strobe_reg <= (cmd.op == OP_ERR_SMALL) || (cmd.op == OP_ERR_NOCOORD)
                       || (cmd.op == OP_ERR_ZERO) || (cmd.op == OP_FINISH);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pp_reg    <= half_a * half_b;
        pp_p_reg  <= mul_p;
        pp_sh_reg <= 2'({1'b0, mul_k[1]} + {1'b0, mul_k[0]});

        if (pp_v_reg)
        begin
            case (pp_p_reg)
                DST_IXX, DST_IYY: acc_i_reg   <= acc_i_reg + addend;
                DST_XXX, DST_XYY: acc_x_reg   <= acc_x_reg + addend;
                DST_M1:           acc_m1_reg  <= acc_m1_reg + addend;
                DST_M2:           acc_m2_reg  <= acc_m2_reg + addend;
                default:          deg_acc_reg <= deg_acc_reg + addend;
            endcase
        end

        case (cmd.op)
            OP_SC_LOAD:
            begin
                prodx_reg <= vx_sel * s_sel;
                prody_reg <= vy_sel * s_sel;
                vx_reg    <= vx_sel;
                vy_reg    <= vy_sel;
                s_reg     <= s_sel;
                dvs_reg   <= 16'(-s_sel);
                dnx_reg   <= {vx_mag, {FRAC_BITS{1'b0}}};
                dny_reg   <= {vy_mag, {FRAC_BITS{1'b0}}};
                drx_reg   <= '0;
                dry_reg   <= '0;
                negx_reg  <= vx_sel[31];
                negy_reg  <= vy_sel[31];
            end
            OP_SC_DIV:
            begin
                {drx_reg, dnx_reg} <= divx_res;
                {dry_reg, dny_reg} <= divy_res;
            end
            OP_SC_SAVE:
            begin
                px_reg[cmd.corner] <= px_new;
                py_reg[cmd.corner] <= py_new;
            end
            OP_DIFF:
            begin
                il_dx_reg   <= px_reg[1] - px_reg[0];
                il_dy_reg   <= py_reg[1] - py_reg[0];
                xl_dx_reg   <= px_reg[2] - px_reg[0];
                xl_dy_reg   <= py_reg[2] - py_reg[0];
                uix_reg     <= mag64(px_reg[1] - px_reg[0]);
                uiy_reg     <= mag64(py_reg[1] - py_reg[0]);
                uxx_reg     <= mag64(px_reg[2] - px_reg[0]);
                uxy_reg     <= mag64(py_reg[2] - py_reg[0]);
                acc_i_reg   <= '0;
                acc_x_reg   <= '0;
                acc_m1_reg  <= '0;
                acc_m2_reg  <= '0;
                deg_acc_reg <= 128'(HALF_PI);
            end
            OP_SQRT:
            begin
                {rem_i_reg, root_i_reg} <= sqi_res;
                {rem_x_reg, root_x_reg} <= sqx_res;
            end
            OP_NORM_LOAD:
            begin
                cx_reg <= uiy_reg;
                cy_reg <= uix_reg;
                cz_reg <= '0;
            end
            OP_NORM:
            begin
                if (norm_m[63:41] != '0)
                begin
                    cx_reg <= cx_reg >>> 1;
                    cy_reg <= cy_reg >>> 1;
                end
                else if (!norm_m[40])
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            end
            OP_DDIV:
            begin
                dr_reg <= dd_q ? dd_t - PI_Q60 : dd_t;
                dq_reg <= {dq_reg[DEG_W-2:0], dd_q};
            end
            default:
            begin
            end
        endcase

        // rotate toward the x axis; freeze once y reaches zero
        if (cordic_go)
        begin
            if (!cy_reg[63])
            begin
                cx_reg <= cx_reg + (cy_reg >>> cmd.step);
                cy_reg <= cy_reg - (cx_reg >>> cmd.step);
                cz_reg <= cz_reg + signed'(atan_tab[cmd.step]);
            end
            else
            begin
                cx_reg <= cx_reg - (cy_reg >>> cmd.step);
                cy_reg <= cy_reg + (cx_reg >>> cmd.step);
                cz_reg <= cz_reg - signed'(atan_tab[cmd.step]);
            end
        end

        case (cmd.op)
            OP_ERR_SMALL, OP_ERR_NOCOORD, OP_ERR_ZERO:
            begin
                case (cmd.op)
                    OP_ERR_SMALL:   status_reg <= ST_SMALL;
                    OP_ERR_NOCOORD: status_reg <= ST_NOCOORD;
                    default:        status_reg <= ST_ZERO;
                endcase
                org_x_reg <= '0;
                org_y_reg <= '0;
                az_reg    <= '0;
                il_sp_reg <= '0;
                xl_sp_reg <= '0;
            end
            OP_FINISH:
            begin
                status_reg <= ST_OK;
                org_x_reg  <= px_reg[0][62:0];
                org_y_reg  <= py_reg[0][62:0];
                az_reg     <= il_dx_reg[63] ? ~dq_reg + 25'd1 : dq_reg;
                il_sp_reg  <= (uiy_reg < uix_reg) ? ~isp_sat + 63'd1 : isp_sat;
                xl_sp_reg  <= xl_neg ? ~xsp_sat + 63'd1 : xsp_sat;
            end
            default:
            begin
            end
        endcase
    end

    assign strobe            = strobe_reg;
    assign status            = status_reg;
    assign origin_x          = org_x_reg;
    assign origin_y          = org_y_reg;
    assign azimuth           = az_reg;
    assign inline_spacing    = il_sp_reg;
    assign crossline_spacing = xl_sp_reg;

endmodule

// ----- rtl/core/bin_grid_from_corner_traces.sv -----
// Bin grid from three corner traces. Start while idle stores corners (0,0) and (1,0).
// The (0,1) corner starts the grid, which runs through the bit-serial scalar divider,
// the multiplier, the 64-step square root, normalising, 61 CORDIC steps and the
// degree divider before the result strobe.
// busy is high meanwhile; one grid at a time. Results cannot be held off.
// rst_n clears stores, grid sizes and the sequencer asynchronously.
`include "assert_macros.svh"
module bin_grid_from_corner_traces
    import bgc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         corner_index,
    input  logic signed [31:0] cdp_x,
    input  logic signed [31:0] cdp_y,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    input  logic signed [15:0] coord_scalar,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [62:0] origin_x,
    output logic signed [62:0] origin_y,
    output logic signed [24:0] azimuth,
    output logic signed [62:0] inline_spacing,
    output logic signed [62:0] crossline_spacing
);

    cmd_t  cmd;
    stat_t stat;

    // register writes are never stalled: cfg_ready is tied high
    assign cfg_ready = 1'b1;

    bgc_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .corner_index (corner_index),
        .busy         (busy),
        .cmd          (cmd),
        .stat         (stat)
    );

    bgc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .corner_index      (corner_index),
        .cdp_x             (cdp_x),
        .cdp_y             (cdp_y),
        .source_x          (source_x),
        .source_y          (source_y),
        .coord_scalar      (coord_scalar),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .strobe            (strobe),
        .status            (status),
        .origin_x          (origin_x),
        .origin_y          (origin_y),
        .azimuth           (azimuth),
        .inline_spacing    (inline_spacing),
        .crossline_spacing (crossline_spacing)
    );

    `BGC_ASSERT_SAME(a_strobe_idle, strobe, !busy, "result strobe while grid still in work")
    `BGC_ASSERT_NEXT(a_strobe_single, strobe, !strobe, "result strobe held for two cycles")
    `BGC_ASSERT_NEXT(a_trigger_busy, start && !busy && corner_index == CORNER_TRIG, busy, "third corner did not start the grid")
    `BGC_ASSERT_SAME(a_err_zero, strobe && status != ST_OK, origin_x == '0 && azimuth == '0 && inline_spacing == '0 && crossline_spacing == '0, "error result carries non-zero fields")

endmodule

// ----- test/bin_grid_from_corner_traces_tb.sv -----
// Self-checking testbench for bin_grid_from_corner_traces: corners come with random gaps,
// grid sizes change between phases; each result is checked against a bit-exact predictor.
// Depends on bgc_pkg and the bin_grid_from_corner_traces RTL.
`timescale 1ns / 1ps
module bin_grid_from_corner_traces_tb;
    import bgc_pkg::*;

    localparam int FRAC = 16;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]         corner;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [15:0] scl;
    } corner_item_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [62:0] ox;
        logic [62:0] oy;
        logic [24:0] az;
        logic [62:0] il;
        logic [62:0] xl;
    } grid_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] corner_index;
    logic signed [31:0] cdp_x, cdp_y, source_x, source_y;
    logic signed [15:0] coord_scalar;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [15:0] cfg_data;
    logic strobe;
    logic [1:0] status;
    logic signed [62:0] origin_x, origin_y, inline_spacing, crossline_spacing;
    logic signed [24:0] azimuth;

    bin_grid_from_corner_traces #(.FRAC_BITS(FRAC)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .corner_index(corner_index), .cdp_x(cdp_x), .cdp_y(cdp_y),
        .source_x(source_x), .source_y(source_y), .coord_scalar(coord_scalar),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .strobe(strobe), .status(status),
        .origin_x(origin_x), .origin_y(origin_y), .azimuth(azimuth),
        .inline_spacing(inline_spacing), .crossline_spacing(crossline_spacing)
    );

    corner_item_t pending_corners[$];
    grid_t        expected_grids[$];
    int           mismatches;
    longint unsigned cycles;
    logic         took;
    int           gap;

    // predictor state
    logic [15:0]        n_inlines, n_crosslines;
    logic signed [31:0] st_cx[3], st_cy[3], st_sx[3], st_sy[3];
    logic signed [15:0] st_scl[3];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [63:0] atan_q60(input int i);
        logic signed [63:0] acc;
        int k;
        int e;
        acc = 0;
        if (i == 0)
            return PI_Q60 >> 2;
        for (k = 0; k < 64; k++)
        begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0)
            begin
                if (k % 2 == 1)
                    acc = acc - ((64'd1 << e) / (2 * k + 1));
                else
                    acc = acc + ((64'd1 << e) / (2 * k + 1));
            end
        end
        return acc;
    endfunction

    // first-quadrant angle of (ax, ay) in Q60 radians, CORDIC vectoring
    function automatic logic [63:0] quadrant_angle(input logic [63:0] ax_in,
                                                   input logic [63:0] ay_in);
        logic [63:0] ax, ay, m;
        logic signed [63:0] x, y, z, xs, ys, a;
        int top;
        int i;
        ax = ax_in;
        ay = ay_in;
        m = (ax > ay) ? ax : ay;
        top = 63;
        while (!m[top])
            top--;
        if (top > 40)
        begin
            ax = ax >> (top - 40);
            ay = ay >> (top - 40);
        end
        else
        begin
            ax = ax << (40 - top);
            ay = ay << (40 - top);
        end
        x = ax;
        y = ay;
        z = 0;
        for (i = 0; i < 61 && y != 0; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            a  = atan_q60(i);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end
        end
        if (z < 0)
            z = 0;
        if (z > (PI_Q60 >> 1))
            z = PI_Q60 >> 1;
        return z;
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0] r, t;
        int b;
        r = 0;
        for (b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [64:0] scaled(input logic signed [31:0] v,
                                                  input logic signed [15:0] s);
        logic signed [64:0] q;
        q = 65'(v) * 65'sd65536;
        if (s > 0)
            return q * 65'(s);
        if (s < 0)
            return q / (-65'(s));
        return q;
    endfunction

    function automatic logic [63:0] mag(input logic signed [64:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // store one corner; the (0,1) corner returns the grid it completes
    function automatic bit predict_grid(input corner_item_t it, output grid_t g);
        logic signed [64:0] px[3], py[3];
        logic signed [64:0] idx, idy, xdx, xdy;
        logic signed [131:0] cross_sum;
        logic [63:0] uix, uiy, uxx, uxy, isp, xsp, phi, amag;
        logic [127:0] deg;
        bit present;
        bit use_src;
        int c;
        g = '{default: '0};
        if (it.corner == CORNER_SKIP)
            return 0;
        st_cx[it.corner] = it.cx;
        st_cy[it.corner] = it.cy;
        st_sx[it.corner] = it.sx;
        st_sy[it.corner] = it.sy;
        st_scl[it.corner] = it.scl;
        if (it.corner != CORNER_TRIG)
            return 0;
        present = 0;
        use_src = 0;
        for (c = 0; c < 3; c++)
            if (st_cx[c] != 0 || st_cy[c] != 0)
                present = 1;
        if (!present)
        begin
            use_src = 1;
            for (c = 0; c < 3; c++)
                if (st_sx[c] != 0 || st_sy[c] != 0)
                    present = 1;
        end
        if (n_inlines < 2 || n_crosslines < 2)
            g.st = ST_SMALL;
        else if (!present)
            g.st = ST_NOCOORD;
        else
        begin
            for (c = 0; c < 3; c++)
            begin
                px[c] = scaled(use_src ? st_sx[c] : st_cx[c], st_scl[c]);
                py[c] = scaled(use_src ? st_sy[c] : st_cy[c], st_scl[c]);
            end
            idx = px[1] - px[0];
            idy = py[1] - py[0];
            xdx = px[2] - px[0];
            xdy = py[2] - py[0];
            uix = mag(idx);
            uiy = mag(idy);
            uxx = mag(xdx);
            uxy = mag(xdy);
            isp = root_floor({64'd0, uix} * {64'd0, uix} + {64'd0, uiy} * {64'd0, uiy});
            xsp = root_floor({64'd0, uxx} * {64'd0, uxx} + {64'd0, uxy} * {64'd0, uxy});
            if (isp == 0 || xsp == 0)
                g.st = ST_ZERO;
            else
            begin
                g.st = ST_OK;
                if (isp > SPACING_MAX)
                    isp = SPACING_MAX;
                if (xsp > SPACING_MAX)
                    xsp = SPACING_MAX;
                phi  = quadrant_angle(uiy, uix);
                amag = (idy < 0) ? PI_Q60 - phi : phi;
                deg  = ({64'd0, amag} * 128'd11796480 + {64'd0, PI_Q60 >> 1})
                       / {64'd0, PI_Q60};
                g.ox = px[0][62:0];
                g.oy = py[0][62:0];
                g.az = (idx < 0) ? -deg[24:0] : deg[24:0];
                g.il = (uiy < uix) ? -isp[62:0] : isp[62:0];
                cross_sum = 132'(idy) * 132'(xdx) + 132'(idx) * 132'(xdy);
                g.xl = (cross_sum < 0) ? -xsp[62:0] : xsp[62:0];
            end
        end
        return 1;
    endfunction

    // driver: present the next corner at the falling edge, with a random hold-off
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (gap > 0)
            begin
                gap = gap - 1;
                start <= 1'b0;
            end
            else if (pending_corners.size() > 0)
            begin
                corner_item_t it;
                it = pending_corners.pop_front();
                corner_index <= it.corner;
                cdp_x <= it.cx;
                cdp_y <= it.cy;
                source_x <= it.sx;
                source_y <= it.sy;
                coord_scalar <= it.scl;
                start <= 1'b1;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: take transfers and check results at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            took <= 1'b0;
        else
        begin
            corner_item_t it;
            grid_t g;
            grid_t want;
            took <= start && !busy;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_INLINE)
                    n_inlines = cfg_data;
                else
                    n_crosslines = cfg_data;
            end
            if (start && !busy)
            begin
                it = '{corner_index, cdp_x, cdp_y, source_x, source_y, coord_scalar};
                if (predict_grid(it, g))
                    expected_grids.push_back(g);
            end
            if (strobe)
            begin
                g = '{status, origin_x, origin_y, azimuth, inline_spacing,
                      crossline_spacing};
                if (expected_grids.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected grid result: %p", g);
                end
                else
                begin
                    want = expected_grids.pop_front();
                    if (g != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("grid mismatch: expected %p, got %p", want, g);
                    end
                end
            end
        end
    end

    task automatic add_corner(input logic [1:0] c, input logic [31:0] cx,
                              input logic [31:0] cy, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [15:0] s);
        pending_corners.push_back('{c, cx, cy, sx, sy, s});
    endtask

    task automatic wait_idle();
        while (pending_corners.size() > 0 || start || expected_grids.size() > 0 || busy)
            @(posedge clk);
        // corners without results may still be in flight
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_scalar();
        case ($urandom_range(0, 7))
            0: return 16'sd0;
            1: return 16'sd1;
            2: return 16'(-$signed(16'($urandom_range(1, 100))));
            3: return 16'($urandom_range(1, 100));
            4: return 16'($urandom);
            default: return 16'(-$signed(16'($urandom_range(1, 10))));
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(-$signed(32'($urandom_range(0, 100000))));
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($urandom_range(0, 2000000));
        endcase
    endfunction

    task automatic add_random_grid();
        bit no_cdp;
        int c;
        no_cdp = ($urandom_range(0, 4) == 0);
        for (c = 0; c < 3; c++)
        begin
            if (no_cdp)
                add_corner(2'(c), 0, 0, pick_coord(), pick_coord(), pick_scalar());
            else
                add_corner(2'(c), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                           pick_scalar());
        end
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        corner_index = '0;
        cdp_x = '0;
        cdp_y = '0;
        source_x = '0;
        source_y = '0;
        coord_scalar = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_INLINE;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        gap = 0;
        n_inlines = '0;
        n_crosslines = '0;
        for (int c = 0; c < 3; c++)
        begin
            st_cx[c] = '0;
            st_cy[c] = '0;
            st_sx[c] = '0;
            st_sy[c] = '0;
            st_scl[c] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // grid too small with reset sizes, and with one size still below two
        add_corner(CORNER_TRIG, 5, 6, 7, 8, 16'sd1);
        wait_idle();
        write_reg(CFG_INLINE, 16'd1);
        write_reg(CFG_CROSS, 16'd5);
        add_corner(CORNER_TRIG, 5, 6, 7, 8, 16'sd1);
        wait_idle();
        write_reg(CFG_INLINE, 16'd2);
        write_reg(CFG_CROSS, 16'd2);

        // no coordinates, then source fallback, then ignored corner three
        add_corner(2'd0, 0, 0, 0, 0, 16'sd0);
        add_corner(2'd1, 0, 0, 0, 0, 16'sd0);
        add_corner(CORNER_TRIG, 0, 0, 0, 0, 16'sd0);
        add_corner(2'd1, 0, 0, 100, 0, 16'sd0);
        add_corner(CORNER_SKIP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
        add_corner(CORNER_TRIG, 0, 0, 0, 50, -16'sd10);
        // zero spacing: identical corners
        add_corner(2'd0, 9, 9, 0, 0, 16'sd1);
        add_corner(2'd1, 9, 9, 0, 0, 16'sd1);
        add_corner(CORNER_TRIG, 12, 3, 0, 0, 16'sd1);
        // inline straight south: azimuth of half a turn
        add_corner(2'd1, 9, 4, 0, 0, 16'sd1);
        add_corner(CORNER_TRIG, 20, 9, 0, 0, 16'sd1);
        // field extremes and saturating spacings
        add_corner(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   16'sd32767);
        add_corner(2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   16'sd32767);
        add_corner(CORNER_TRIG, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 16'h8000);
        add_corner(2'd0, 32'h7FFF_FFFF, -5, 0, 0, 16'h8000);
        add_corner(2'd1, -3, 32'h8000_0000, 0, 0, 16'hFFFF);
        add_corner(CORNER_TRIG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                   16'h7FFF);
        wait_idle();
        write_reg(CFG_INLINE, 16'hFFFF);
        write_reg(CFG_CROSS, 16'hFFFF);

        for (phase = 0; phase < 6; phase++)
        begin
            for (n = 0; n < 80; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_corner(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                               $urandom, 16'($urandom));
                else
                begin
                    add_random_grid();
                    n = n + 2;
                end
            end
            wait_idle();
            case (phase)
                0: write_reg(CFG_CROSS, 16'd2);
                1: write_reg(CFG_INLINE, 16'd0);
                2: write_reg(CFG_INLINE, 16'($urandom_range(2, 65535)));
                3: write_reg(CFG_CROSS, 16'd1);
                default: write_reg(CFG_CROSS, 16'($urandom_range(2, 65535)));
            endcase
        end

        wait_idle();
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_grids.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
